@@ hw/rtl/mlc_pkg.sv @@
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared widths, constants and the elaboration-time companding tables of the
// mu-law sample codec.
// ----------------------------------------------------------------------------
package mlc_pkg;

	// Field widths.
	localparam int unsigned GainW   = 4;
	localparam int unsigned WordW   = 32;
	localparam int unsigned CodeW   = 8;
	localparam int unsigned SampleW = 16;
	localparam int unsigned MagW    = SampleW + 1;
	localparam int unsigned ProdW   = SampleW + GainW + 1;
	localparam int unsigned Levels  = 128;
	localparam int unsigned LevelW  = $clog2(Levels);

	// Default position of the sample inside the microphone word.
	localparam int unsigned MicShiftDefault = 14;

	// Gain after reset.
	localparam logic [GainW-1:0] GainReset = GainW'(1);

	// Operation codes.
	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef logic [MagW-1:0]                  thr_t;
	typedef thr_t [Levels-1:0]                thr_tbl_t;
	typedef logic [SampleW-1:0]               mag_t;
	typedef mag_t [Levels-1:0]                mag_tbl_t;

	// Fixed-point constants of the table builder (Q2.62 and Q38).
	localparam logic [63:0] OneQ62 = 64'd1 << 62;
	localparam logic [63:0] TwoQ62 = 64'd1 << 63;
	localparam logic [63:0] OneQ38 = 64'd1 << 38;
	localparam logic [63:0] Den    = 64'd255 << 38;

	// (a * b) >> 62 for Q2.62 operands whose product stays below 4.0.
	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		logic [63:0] ah, al, bh, bl, ll, lh, hl, hh, mid, lo, hi;
		ah  = a >> 32;
		al  = a & 64'hFFFF_FFFF;
		bh  = b >> 32;
		bl  = b & 64'hFFFF_FFFF;
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = (ll >> 32) + (lh & 64'hFFFF_FFFF) + (hl & 64'hFFFF_FFFF);
		lo  = (ll & 64'hFFFF_FFFF) | (mid << 32);
		hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << 2) | (lo >> 62);
	endfunction

	// True when x^127 stays below 2.0.
	function automatic logic pow127_below_two(logic [63:0] x);
		logic [63:0] acc;
		logic        ok;
		acc = OneQ62;
		ok  = 1'b1;
		for (int i = 0; i < 127; i++) begin
			if (ok) begin
				acc = qmul(acc, x);
				if (acc >= TwoQ62) ok = 1'b0;
			end
		end
		return ok;
	endfunction

	// Largest Q2.62 value whose 127th power is below two, bit by bit.
	function automatic logic [63:0] calc_root();
		logic [63:0] root, cand;
		root = OneQ62;
		for (int b = 61; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (pow127_below_two(cand)) root = cand;
		end
		return root;
	endfunction

	// 256^(k/127) - 1 in Q38.
	function automatic logic [63:0] calc_diff(logic [63:0] root, int unsigned k);
		int unsigned t, q, r;
		logic [63:0] pw, p38;
		t  = k * 8;
		q  = t / 127;
		r  = t % 127;
		pw = OneQ62;
		for (int unsigned j = 0; j < 127; j++) begin
			if (j < r) pw = qmul(pw, root);
		end
		p38 = (pw >> 24) << q;
		return p38 - OneQ38;
	endfunction

	function automatic thr_tbl_t calc_enc_tbl(logic [63:0] root);
		thr_tbl_t    tbl;
		logic [63:0] diff, val;
		for (int unsigned k = 0; k < Levels; k++) begin
			diff   = calc_diff(root, k);
			val    = (64'd32768 * diff + Den - 64'd1) / Den;
			tbl[k] = val[MagW-1:0];
		end
		return tbl;
	endfunction

	function automatic mag_tbl_t calc_dec_tbl(logic [63:0] root);
		mag_tbl_t    tbl;
		logic [63:0] diff, val;
		for (int unsigned k = 0; k < Levels; k++) begin
			diff   = calc_diff(root, k);
			val    = (64'd32767 * diff) / Den;
			tbl[k] = val[SampleW-1:0];
		end
		return tbl;
	endfunction

	localparam logic [63:0] Root   = calc_root();
	localparam thr_tbl_t    EncThr = calc_enc_tbl(Root);
	localparam mag_tbl_t    DecMag = calc_dec_tbl(Root);

endpackage

@@ hw/rtl/mlc_req_if.sv @@
// ----------------------------------------------------------------------------
// mlc_req_if
// Request channel of the codec: operation select, microphone word and code.
// ----------------------------------------------------------------------------
interface mlc_req_if
	import mlc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [WordW-1:0]    mic_word;
	logic [CodeW-1:0]    code_in;

	modport source (output valid, output operation, output mic_word, output code_in,
		input ready);
	modport sink (input valid, input operation, input mic_word, input code_in,
		output ready);
endinterface

@@ hw/rtl/mlc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mlc_rsp_if
// Result channel of the codec: code byte, linear sample and DAC word.
// ----------------------------------------------------------------------------
interface mlc_rsp_if
	import mlc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CodeW-1:0]    code_out;
	logic [SampleW-1:0]  sample_out;
	logic [WordW-1:0]    dac_word;

	modport source (output valid, output code_out, output sample_out, output dac_word,
		input ready);
	modport sink (input valid, input code_out, input sample_out, input dac_word,
		output ready);
endinterface

@@ hw/rtl/mlc_quantizer.sv @@
// ----------------------------------------------------------------------------
// mlc_quantizer
// Compares a sample magnitude against the encode thresholds of levels 1 to
// 127 at once and returns the thermometer of levels reached.
// ----------------------------------------------------------------------------
module mlc_quantizer
	import mlc_pkg::*;
(
	input  logic [MagW-1:0]   mag,
	output logic [Levels-1:0] therm
);

	// Level zero is always reached and is not counted.
	always_comb begin
		therm[0] = 1'b0;
		for (int k = 1; k < Levels; k++) begin
			therm[k] = (mag >= EncThr[k]);
		end
	end

endmodule

@@ hw/rtl/mu_law_sample_codec.sv @@
// ----------------------------------------------------------------------------
// mu_law_sample_codec
// Continuous mu-law (mu = 255) compander with 8-bit codes.
//
// The req channel carries one item per sample: operation selects encode of a
// microphone word or decode of a received code byte. The rsp channel returns
// one result item per request item, in order. For encode, code_out holds the
// code and sample_out the gained, saturated sample; dac_word is zero. For
// decode, sample_out holds the decoded sample, dac_word the sample in bits
// 31:16, and code_out is zero. Gain is loaded through cfg_we / cfg_wdata, and
// the user must load it only while no item is in flight; the block does not
// enforce this.
// One item is accepted every cycle while req.ready is high. The five stages
// are: sample extract and gain multiply, saturation and decode table read,
// threshold compare, partial level counts, final count and output register.
// Reset empties the pipeline and sets gain to one. When the receiver stalls,
// items close up behind the output register and req.ready falls only once
// every stage holds an item.
// ----------------------------------------------------------------------------
module mu_law_sample_codec
	import mlc_pkg::*;
#(
	parameter int unsigned MIC_SHIFT = MicShiftDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [GainW-1:0] cfg_wdata,
	mlc_req_if.sink          req,
	mlc_rsp_if.source        rsp
);

	localparam int unsigned Groups = 8;
	localparam int unsigned GroupW = Levels / Groups;
	localparam int unsigned GCntW  = $clog2(GroupW + 1);

	logic [GainW-1:0] gain_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic                      op_s1;
	logic signed [ProdW-1:0]   prod_s1;
	logic [CodeW-1:0]          code_s1;

	logic                      op_s2;
	logic [SampleW-1:0]        sample_s2;
	logic [MagW-1:0]           mag_s2;
	logic                      neg_s2;

	logic                      op_s3;
	logic [SampleW-1:0]        sample_s3;
	logic                      neg_s3;
	logic [Levels-1:0]         therm_s3;

	logic                      op_s4;
	logic [SampleW-1:0]        sample_s4;
	logic                      neg_s4;
	logic [Groups-1:0][GCntW-1:0] gcnt_s4;

	logic                      op_s5;
	logic [SampleW-1:0]        sample_s5;
	logic [CodeW-1:0]          code_s5;

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// Each stage takes a new item when it is empty or its item moves on.
	assign rdy_s5    = !v_s5 || rsp.ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: take the 16-bit sample out of the word and apply the gain.
	logic signed [SampleW-1:0] mic_smp;
	logic signed [ProdW-1:0]   prod_d;

	assign mic_smp = $signed(req.mic_word[MIC_SHIFT +: SampleW]);
	assign prod_d  = ProdW'(mic_smp) * $signed(ProdW'({1'b0, gain_q}));

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			op_s1   <= req.operation;
			prod_s1 <= prod_d;
			code_s1 <= req.code_in;
		end
	end

	// Stage 2: saturate and take the magnitude; read the decode table.
	logic [SampleW-1:0] amp_d;
	logic [MagW-1:0]    amp_ext;
	logic [MagW-1:0]    mag_d;
	logic               cneg;
	logic [LevelW-1:0]  cabs;
	logic [CodeW-1:0]   cneg_val;
	logic [SampleW-1:0] dmag;
	logic [SampleW-1:0] dsamp_d;

	always_comb begin
		priority if (prod_s1 > ProdW'(32767)) begin
			amp_d = 16'h7FFF;
		end else if (prod_s1 < -ProdW'(32768)) begin
			amp_d = 16'h8000;
		end else begin
			amp_d = prod_s1[SampleW-1:0];
		end
		amp_ext = {amp_d[SampleW-1], amp_d};
		mag_d   = amp_d[SampleW-1] ? MagW'(-amp_ext) : amp_ext;
	end

	always_comb begin
		cneg     = code_s1[CodeW-1];
		cneg_val = CodeW'(-code_s1);
		cabs     = cneg ? cneg_val[LevelW-1:0] : code_s1[LevelW-1:0];
		dmag     = DecMag[cabs];
		// The most negative code saturates to full scale.
		priority if (code_s1 == 8'h80) begin
			dsamp_d = 16'h8000;
		end else if (cneg) begin
			dsamp_d = SampleW'(-dmag);
		end else begin
			dsamp_d = dmag;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			op_s2     <= op_s1;
			sample_s2 <= (op_s1 == OP_DECODE) ? dsamp_d : amp_d;
			mag_s2    <= mag_d;
			neg_s2    <= amp_d[SampleW-1];
		end
	end

	// Stage 3: compare the magnitude with every threshold.
	logic [Levels-1:0] therm_d;

	mlc_quantizer u_quant (
		.mag   (mag_s2),
		.therm (therm_d)
	);

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			op_s3     <= op_s2;
			sample_s3 <= sample_s2;
			neg_s3    <= neg_s2;
			therm_s3  <= therm_d;
		end
	end

	// Stage 4: count reached levels in groups.
	logic [Groups-1:0][GCntW-1:0] gcnt_d;

	always_comb begin
		for (int g = 0; g < Groups; g++) begin
			gcnt_d[g] = '0;
			for (int b = 0; b < GroupW; b++) begin
				gcnt_d[g] = gcnt_d[g] + GCntW'(therm_s3[g*GroupW + b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			op_s4     <= op_s3;
			sample_s4 <= sample_s3;
			neg_s4    <= neg_s3;
			gcnt_s4   <= gcnt_d;
		end
	end

	// Stage 5: total level, sign and the output register.
	logic [CodeW-1:0] level_d;
	logic [CodeW-1:0] code_d;

	always_comb begin
		level_d = '0;
		for (int g = 0; g < Groups; g++) begin
			level_d = level_d + CodeW'(gcnt_s4[g]);
		end
		if (op_s4 == OP_DECODE) begin
			code_d = '0;
		end else if (neg_s4) begin
			code_d = CodeW'(-level_d);
		end else begin
			code_d = level_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			op_s5     <= op_s4;
			sample_s5 <= sample_s4;
			code_s5   <= code_d;
		end
	end

	assign rsp.valid      = v_s5;
	assign rsp.code_out   = code_s5;
	assign rsp.sample_out = sample_s5;
	assign rsp.dac_word   = (op_s5 == OP_DECODE) ? {sample_s5, 16'h0000} : '0;

	// A zero sample always encodes to the zero code.
	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (op_s5 == OP_ENCODE) && (sample_s5 == '0) |-> code_s5 == '0)
		else $error("zero sample encoded to a nonzero code");

	// An encoded code carries the sign of its sample, or is zero.
	a_code_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (op_s5 == OP_ENCODE) |->
		(code_s5[CodeW-1] == sample_s5[SampleW-1]) || (code_s5 == '0))
		else $error("code sign differs from sample sign");

	// Decode results carry the sample in the upper half of the DAC word.
	a_dac: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (op_s5 == OP_DECODE) |->
		(rsp.dac_word[31:16] == sample_s5) && (rsp.dac_word[15:0] == 16'h0000))
		else $error("DAC word does not match decoded sample");

	// An item behind a stalled output stays in stage 4.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && v_s5 && !rsp.ready |=> v_s4)
		else $error("item lost behind stalled output");

endmodule

@@ test/mu_law_sample_codec_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mu_law_sample_codec_test
// Self-checking bench for the mu-law sample codec. A driver feeds request
// items from a pending queue, and a monitor compares every result item with
// the oldest prediction. Predictions come from level tables that the bench
// builds itself with exact fixed-point arithmetic. The run walks through
// several gain settings, random gaps and stalls, and one long output stall.
// ----------------------------------------------------------------------------
module mu_law_sample_codec_test;
	import mlc_pkg::*;

	localparam int          HalfPeriod = 5;
	localparam int          CycleLimit = 400000;
	localparam int          PipeDepth  = 5;
	localparam int          LongHold   = 80;
	localparam int          ReportMax  = 30;
	localparam int          MicShift   = MicShiftDefault;
	localparam logic [63:0] UnityQ62   = 64'd1 << 62;
	localparam logic [63:0] DoubleQ62  = 64'd1 << 63;
	localparam logic [63:0] UnityQ38   = 64'd1 << 38;
	localparam logic [63:0] LevelDen   = 64'd255 << 38;

	typedef struct {
		op_t              op;
		logic [WordW-1:0] mic;
		logic [CodeW-1:0] code;
	} codec_item_t;

	typedef struct {
		logic [CodeW-1:0]   code;
		logic [SampleW-1:0] sample;
		logic [WordW-1:0]   dac;
	} codec_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [GainW-1:0] cfg_wdata;

	mlc_req_if req_ch ();
	mlc_rsp_if rsp_ch ();

	mu_law_sample_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Level tables: encode thresholds and decode magnitudes.
	int enc_level_thr [Levels];
	int dec_level_mag [Levels];

	logic [GainW-1:0] gain_setting;
	bit   [15:0]      gains_used;

	codec_item_t   pending_items [$];
	codec_result_t expected_results [$];
	codec_item_t   cur_item;

	bit offering;
	bit no_idle;
	int gap_left;
	int stall_left;
	int hold_left;
	int hold_requests;
	int hold_served;
	int encode_count;
	int decode_count;
	int result_count;
	int error_count;
	int cycle_count;

	// Clock generation.
	initial clk = 1'b0;
	always #HalfPeriod clk = ~clk;

	// (a * b) >> 62 for Q2.62 operands, taken from a full-width product.
	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// True when x raised to the 127th power is still below two.
	function automatic bit power127_under_two(logic [63:0] x);
		logic [63:0] acc;
		acc = UnityQ62;
		for (int i = 0; i < 127; i++) begin
			acc = mul_q62(acc, x);
			if (acc >= DoubleQ62)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Builds both level tables from the 127th root of two.
	task automatic build_level_tables();
		logic [63:0] root, cand, p38, diff;
		logic [63:0] pw [127];
		int unsigned t, q, r;
		root = UnityQ62;
		for (int b = 61; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (power127_under_two(cand))
				root = cand;
		end
		pw[0] = UnityQ62;
		for (int j = 1; j < 127; j++)
			pw[j] = mul_q62(pw[j - 1], root);
		for (int k = 0; k < Levels; k++) begin
			t = k * 8;
			q = t / 127;
			r = t % 127;
			p38 = (pw[r] >> 24) << q;
			diff = p38 - UnityQ38;
			enc_level_thr[k] = int'((64'd32768 * diff + LevelDen - 64'd1) / LevelDen);
			dec_level_mag[k] = int'((64'd32767 * diff) / LevelDen);
		end
	endtask

	// Expected result of one request item under the current gain.
	function automatic codec_result_t companded_result(codec_item_t it);
		codec_result_t       res;
		logic signed [15:0]  s;
		logic signed [7:0]   v;
		int                  amp, mag, lvl, smp;
		res.code = '0;
		res.sample = '0;
		res.dac = '0;
		if (it.op == OP_ENCODE) begin
			s = it.mic[MicShift +: SampleW];
			amp = int'(s) * int'(gain_setting);
			if (amp > 32767)
				amp = 32767;
			if (amp < -32768)
				amp = -32768;
			mag = (amp < 0) ? -amp : amp;
			lvl = 0;
			for (int k = 1; k < Levels; k++)
				if (mag >= enc_level_thr[k])
					lvl++;
			if (amp < 0)
				lvl = -lvl;
			res.code = lvl[CodeW-1:0];
			res.sample = amp[SampleW-1:0];
		end else begin
			v = it.code;
			// The most negative code has no table entry and saturates.
			if (v == -8'sd128)
				smp = -32768;
			else if (v < 0)
				smp = -dec_level_mag[-int'(v)];
			else
				smp = dec_level_mag[int'(v)];
			res.sample = smp[SampleW-1:0];
			res.dac = {smp[SampleW-1:0], 16'h0000};
		end
		return res;
	endfunction

	// Idle cycles before an item or after a result; none in quiet phases.
	function automatic int idle_draw();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// Microphone word carrying a sample, with random filler around it.
	function automatic logic [WordW-1:0] word_for_sample(int s);
		logic [WordW-1:0] w;
		w = $urandom;
		w[MicShift +: SampleW] = s[SampleW-1:0];
		return w;
	endfunction

	task automatic queue_item(op_t op, logic [WordW-1:0] mic, logic [CodeW-1:0] code);
		codec_item_t it;
		it.op = op;
		it.mic = mic;
		it.code = code;
		pending_items.push_back(it);
	endtask

	// Random sample aimed at small values, level boundaries and full scale.
	function automatic int pick_sample();
		logic [15:0] raw;
		int          s, t, g;
		case ($urandom_range(0, 3))
			0: begin
				raw = 16'($urandom);
				s = int'($signed(raw));
			end
			1: begin
				s = $urandom_range(0, 1 << $urandom_range(0, 15));
			end
			2: begin
				t = enc_level_thr[$urandom_range(1, Levels - 1)];
				g = int'(gain_setting);
				s = (g == 0) ? t : (t + g - 1) / g;
				s = s + int'($urandom_range(0, 2)) - 1;
			end
			default: begin
				s = 32767 - int'($urandom_range(0, 1));
			end
		endcase
		if ($urandom_range(0, 1))
			s = -s;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s;
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				queue_item(OP_ENCODE, word_for_sample(pick_sample()), CodeW'($urandom));
			else
				queue_item(OP_DECODE, $urandom, CodeW'($urandom));
		end
	endtask

	// Waits until every item went in and every result came back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || offering || expected_results.size() != 0);
		repeat (PipeDepth + 1) @(posedge clk);
	endtask

	task automatic write_gain(logic [GainW-1:0] g);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		gain_setting = g;
		gains_used[g] = 1'b1;
	endtask

	// Driver: offers pending items with random gaps between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
			gap_left = 0;
		end else begin
			if (offering && req_ch.ready) begin
				expected_results.push_back(companded_result(cur_item));
				if (cur_item.op == OP_ENCODE)
					encode_count++;
				else
					decode_count++;
				offering = 1'b0;
				gap_left = idle_draw();
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					req_ch.operation <= cur_item.op;
					req_ch.mic_word <= cur_item.mic;
					req_ch.code_in <= cur_item.code;
					offering = 1'b1;
				end
			end
			req_ch.valid <= offering;
		end
	end

	// Monitor: checks each result item and stalls the output at random.
	always @(posedge clk) begin
		codec_result_t want;
		bit            take_next;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				result_count++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= ReportMax)
						$display("%0t: result item with none expected: code %h sample %h dac %h",
							$time, rsp_ch.code_out, rsp_ch.sample_out, rsp_ch.dac_word);
				end else begin
					want = expected_results.pop_front();
					if (rsp_ch.code_out !== want.code) begin
						error_count++;
						if (error_count <= ReportMax)
							$display("%0t: code_out expected %h actual %h",
								$time, want.code, rsp_ch.code_out);
					end
					if (rsp_ch.sample_out !== want.sample) begin
						error_count++;
						if (error_count <= ReportMax)
							$display("%0t: sample_out expected %h actual %h",
								$time, want.sample, rsp_ch.sample_out);
					end
					if (rsp_ch.dac_word !== want.dac) begin
						error_count++;
						if (error_count <= ReportMax)
							$display("%0t: dac_word expected %h actual %h",
								$time, want.dac, rsp_ch.dac_word);
					end
				end
				stall_left = idle_draw();
			end
			// A long hold-off is counted here, while the sender keeps going.
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LongHold;
			end
			take_next = (hold_left == 0 && stall_left == 0);
			if (hold_left > 0)
				hold_left--;
			else if (stall_left > 0)
				stall_left--;
			rsp_ch.ready <= take_next;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
			$display("mu_law_sample_codec: mismatch");
			$finish;
		end
	end

	// Stimulus: directed items, then random phases at several gains.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ENCODE;
		req_ch.mic_word = '0;
		req_ch.code_in = '0;
		rsp_ch.ready = 1'b0;
		gain_setting = 4'd1;
		gains_used = 16'h0002;
		no_idle = 1'b0;
		hold_requests = 0;
		hold_served = 0;
		encode_count = 0;
		decode_count = 0;
		result_count = 0;
		error_count = 0;
		cycle_count = 0;
		build_level_tables();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Gain as it comes out of reset: full scale, zero and level edges.
		queue_item(OP_ENCODE, word_for_sample(0), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(1), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-1), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(32767), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-32768), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(enc_level_thr[1]), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(enc_level_thr[1] - 1), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-enc_level_thr[64]), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(enc_level_thr[64] - 1), 8'h00);
		queue_item(OP_ENCODE, 32'h7FFF_FFFF, 8'hFF);
		queue_item(OP_ENCODE, 32'h8000_0000, 8'h00);
		queue_item(OP_DECODE, 32'h0000_0000, 8'h00);
		queue_item(OP_DECODE, 32'hFFFF_FFFF, 8'h01);
		queue_item(OP_DECODE, 32'h0000_0000, 8'h7F);
		queue_item(OP_DECODE, 32'h0000_0000, 8'h80);
		queue_item(OP_DECODE, 32'h0000_0000, 8'h81);
		queue_item(OP_DECODE, 32'h0000_0000, 8'hFF);
		queue_random(200);
		wait_drained();

		// Zero gain silences every encoded sample.
		write_gain(4'd0);
		queue_item(OP_ENCODE, word_for_sample(32767), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-32768), 8'h00);
		queue_random(150);
		wait_drained();

		// Largest gain drives most samples into saturation.
		write_gain(4'd15);
		queue_item(OP_ENCODE, word_for_sample(32767), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-32768), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(3000), 8'h00);
		queue_item(OP_ENCODE, word_for_sample(-2185), 8'h00);
		queue_random(200);
		wait_drained();

		// Intermediate gains; one phase runs with no idling on either side.
		for (int p = 0; p < 5; p++) begin
			write_gain(4'($urandom_range(2, 14)));
			no_idle = (p == 2);
			queue_random(200);
			wait_drained();
		end

		// Unity gain written back, with the output held off for a long stretch.
		write_gain(4'd1);
		no_idle = 1'b1;
		queue_random(250);
		hold_requests++;
		wait_drained();
		no_idle = 1'b0;

		repeat (PipeDepth + 4) @(posedge clk);
		$display("Checked %0d results from %0d encode and %0d decode items.",
			result_count, encode_count, decode_count);
		$display("Gains exercised (bit per gain): %b; long output hold-offs: %0d.",
			gains_used, hold_served);
		if (error_count == 0 && expected_results.size() == 0)
			$display("mu_law_sample_codec: match");
		else
			$display("mu_law_sample_codec: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mlc_pkg.sv
hw/rtl/mlc_req_if.sv
hw/rtl/mlc_rsp_if.sv
hw/rtl/mlc_quantizer.sv
hw/rtl/mu_law_sample_codec.sv
test/mu_law_sample_codec_test.sv
